// ----- design/lmac_pkg.sv -----
// Shared types and constants for the long multiply-accumulate unit.
// Used by lmac_issue, lmac_cell and arm_long_multiply_accumulate_unit.
// No dependencies.
package lmac_pkg;

    localparam int WORD_W    = 32;
    localparam int DWORD_W   = 2 * WORD_W;
    localparam int DIGIT_W   = 8;
    localparam int NUM_CELLS = DWORD_W / DIGIT_W;
    localparam int COND_W    = 4;
    localparam int FLAGS_W   = 4;

    // Positions inside the packed NZCV flags
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    // Stream packing
    localparam int S_TDATA_W = 136;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

    // Condition field codes
    typedef enum logic [COND_W-1:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } t_cond;

    // Payload handed from cell to cell
    typedef struct packed {
        logic                executed;
        logic                set_flags;
        logic [FLAGS_W-1:0]  flags;
        logic [DWORD_W-1:0]  mcand;   // multiplicand, pre-shifted by one digit per cell
        logic [DWORD_W-1:0]  mplier;  // remaining multiplier digits, lowest next
        logic [DWORD_W-1:0]  acc;     // running sum
    } t_cell_data;

endpackage

// ----- design/arm_long_multiply_accumulate_unit.sv -----
// ARM long multiply / multiply-accumulate (UMULL, SMULL, UMLAL, SMLAL).
// Depends on lmac_pkg, lmac_issue and lmac_cell.
//
// One request is accepted per cycle while the chain is not stalled:
// the 64-bit product is built by a chain of 8 cells, each adding the
// multiplicand times one 8-bit digit of the multiplier, and the last cell's
// register is the output register. The condition code is tested on entry;
// a failed condition gives executed = 0, a zero result and flags unchanged.
// With set_flags, N and Z follow the 64-bit result and C, V pass through.
// The whole chain stalls while a result waits on the output side.
module arm_long_multiply_accumulate_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // multiplicand[31:0], multiplier[63:32], acc_low[95:64], acc_high[127:96],
    // condition[131:128], flags_in[135:132]
    input  logic [lmac_pkg::S_TDATA_W-1:0] s_tdata,
    // is_signed[0], do_accumulate[1], set_flags[2]
    input  logic [lmac_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_low[31:0], result_high[63:32], flags_out[67:64], zero pad[71:68]
    output logic [lmac_pkg::M_TDATA_W-1:0] m_tdata,
    // executed[0]
    output logic [lmac_pkg::M_TUSER_W-1:0] m_tuser
);

    logic                   w_en;
    logic                   w_valid [0:lmac_pkg::NUM_CELLS];
    lmac_pkg::t_cell_data   w_data  [0:lmac_pkg::NUM_CELLS];
    lmac_pkg::t_cell_data   w_last;
    logic [lmac_pkg::FLAGS_W-1:0] w_flags_out;

    // Chain advances unless a result is held at the output
    assign w_en     = !w_valid[lmac_pkg::NUM_CELLS] || m_tready;
    assign s_tready = w_en;
    assign w_valid[0] = s_tvalid;

    // Decode the request
    lmac_issue u_issue (
        .i_mcand         (s_tdata[31:0]),
        .i_mplier        (s_tdata[63:32]),
        .i_acc_low       (s_tdata[95:64]),
        .i_acc_high      (s_tdata[127:96]),
        .i_is_signed     (s_tuser[0]),
        .i_do_accumulate (s_tuser[1]),
        .i_set_flags     (s_tuser[2]),
        .i_condition     (s_tdata[131:128]),
        .i_flags         (s_tdata[135:132]),
        .o_data          (w_data[0])
    );

    // Row of digit cells
    genvar g;
    generate
        for (g = 0; g < lmac_pkg::NUM_CELLS; g++) begin : g_cell
            lmac_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_valid[g]),
                .i_data  (w_data[g]),
                .o_valid (w_valid[g+1]),
                .o_data  (w_data[g+1])
            );
        end
    endgenerate

    assign w_last = w_data[lmac_pkg::NUM_CELLS];

    // N and Z from the finished result when flags are set
    always_comb begin
        w_flags_out = w_last.flags;
        if (w_last.executed && w_last.set_flags) begin
            w_flags_out[lmac_pkg::FLAG_N] = w_last.acc[lmac_pkg::DWORD_W-1];
            w_flags_out[lmac_pkg::FLAG_Z] = (w_last.acc == '0);
        end
    end

    assign m_tvalid = w_valid[lmac_pkg::NUM_CELLS];
    assign m_tdata  = {4'b0000, w_flags_out, w_last.acc};
    assign m_tuser  = w_last.executed;

endmodule

// ----- design/lmac_issue.sv -----
// Front of the unit: condition check, operand widening and accumulator select.
// Depends on lmac_pkg.
module lmac_issue (
    input  logic [lmac_pkg::WORD_W-1:0]  i_mcand,
    input  logic [lmac_pkg::WORD_W-1:0]  i_mplier,
    input  logic [lmac_pkg::WORD_W-1:0]  i_acc_low,
    input  logic [lmac_pkg::WORD_W-1:0]  i_acc_high,
    input  logic                         i_is_signed,
    input  logic                         i_do_accumulate,
    input  logic                         i_set_flags,
    input  logic [lmac_pkg::COND_W-1:0]  i_condition,
    input  logic [lmac_pkg::FLAGS_W-1:0] i_flags,
    output lmac_pkg::t_cell_data         o_data
);

    logic w_n, w_z, w_c, w_v;
    logic w_pass;
    logic w_sa, w_sb;

    assign w_n = i_flags[lmac_pkg::FLAG_N];
    assign w_z = i_flags[lmac_pkg::FLAG_Z];
    assign w_c = i_flags[lmac_pkg::FLAG_C];
    assign w_v = i_flags[lmac_pkg::FLAG_V];

    // Condition test against incoming NZCV
    always_comb begin
        case (lmac_pkg::t_cond'(i_condition))
            lmac_pkg::COND_EQ: w_pass = w_z;
            lmac_pkg::COND_NE: w_pass = !w_z;
            lmac_pkg::COND_CS: w_pass = w_c;
            lmac_pkg::COND_CC: w_pass = !w_c;
            lmac_pkg::COND_MI: w_pass = w_n;
            lmac_pkg::COND_PL: w_pass = !w_n;
            lmac_pkg::COND_VS: w_pass = w_v;
            lmac_pkg::COND_VC: w_pass = !w_v;
            lmac_pkg::COND_HI: w_pass = w_c && !w_z;
            lmac_pkg::COND_LS: w_pass = !w_c || w_z;
            lmac_pkg::COND_GE: w_pass = (w_n == w_v);
            lmac_pkg::COND_LT: w_pass = (w_n != w_v);
            lmac_pkg::COND_GT: w_pass = !w_z && (w_n == w_v);
            lmac_pkg::COND_LE: w_pass = w_z || (w_n != w_v);
            lmac_pkg::COND_AL: w_pass = 1'b1;
            default:           w_pass = 1'b0;
        endcase
    end

    // Sign bits used for widening to 64 bits
    assign w_sa = i_is_signed & i_mcand[lmac_pkg::WORD_W-1];
    assign w_sb = i_is_signed & i_mplier[lmac_pkg::WORD_W-1];

    // A failed condition zeroes operands so the chain yields a zero result
    always_comb begin
        o_data.executed  = w_pass;
        o_data.set_flags = i_set_flags;
        o_data.flags     = i_flags;
        if (w_pass) begin
            o_data.mcand  = {{lmac_pkg::WORD_W{w_sa}}, i_mcand};
            o_data.mplier = {{lmac_pkg::WORD_W{w_sb}}, i_mplier};
            o_data.acc    = i_do_accumulate ? {i_acc_high, i_acc_low} : '0;
        end else begin
            o_data.mcand  = '0;
            o_data.mplier = '0;
            o_data.acc    = '0;
        end
    end

endmodule

// ----- design/lmac_cell.sv -----
// One cell of the multiply chain: adds multiplicand times one multiplier digit.
// Depends on lmac_pkg.
module lmac_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  lmac_pkg::t_cell_data i_data,
    output logic                 o_valid,
    output lmac_pkg::t_cell_data o_data
);

    logic                         r_valid;
    lmac_pkg::t_cell_data         r_data;
    lmac_pkg::t_cell_data         n_data;
    logic [lmac_pkg::DWORD_W-1:0] w_part;

    // 64x8 partial product, truncated to 64 bits
    assign w_part = i_data.mcand
                  * (lmac_pkg::DWORD_W)'(i_data.mplier[lmac_pkg::DIGIT_W-1:0]);

    // Accumulate and move to the next digit
    always_comb begin
        n_data        = i_data;
        n_data.acc    = i_data.acc + w_part;
        n_data.mcand  = i_data.mcand << lmac_pkg::DIGIT_W;
        n_data.mplier = i_data.mplier >> lmac_pkg::DIGIT_W;
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
